// ----- sv/fixed_point_softmax_pow2_defines.svh -----
// Assertion macros shared by the softmax RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef FIXED_POINT_SOFTMAX_POW2_DEFINES_SVH
`define FIXED_POINT_SOFTMAX_POW2_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define SMX_ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one on the next clock edge.
`define SMX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/smx_pkg.sv -----
package smx_pkg;

    localparam int MAX_LEN = 16;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    localparam int SCORE_W = 32;
    localparam int DIFF_W  = SCORE_W + 1;
    localparam int FRAC_W  = 14;
    localparam int SPAN_W  = 18;
    localparam int ARG_W   = SPAN_W + 1;
    localparam int EXP_W   = ARG_W - FRAC_W;
    localparam int SUM_W   = 23;
    localparam int QUOT_W  = 17;
    localparam int PROB_W  = 15;

    // The window below the maximum is 16.0; scores below it contribute nothing.
    localparam logic [ARG_W-1:0] ROUND_UP_SPAN = ARG_W'(8192 + (16 << FRAC_W));
    localparam logic [ARG_W-1:0] ROUND_DN      = ARG_W'(8191);

    localparam logic [PROB_W-1:0]         PROB_MAX  = PROB_W'(32767);
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    // 2^32 / sum with sum >= 2^16: the upper dividend bits leave a remainder of 2^15,
    // and the remaining quotient bits need one step each.
    localparam int                DIV_STEPS    = QUOT_W;
    localparam int                STEP_W       = $clog2(DIV_STEPS + 1);
    localparam logic [SUM_W:0]    DIV_REM_INIT = (SUM_W + 1)'(1 << 15);

    typedef struct packed {
        logic signed [SCORE_W-1:0] value;
        logic                      in_last;
    } smx_item_t;

    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic              out_last;
        logic              overflow;
    } smx_result_t;

endpackage

// ----- sv/smx_div.sv -----
// Restoring divider that forms 2^32 / divisor, one quotient bit per cycle.
// The divisor must be at least 2^16 and stay stable while the divide runs.
module smx_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           go,
    input  logic [smx_pkg::SUM_W-1:0]      divisor,
    output logic                           done,
    output logic [smx_pkg::QUOT_W-1:0]     quot
);

    logic                           run_reg,  run_next;
    logic                           done_reg, done_next;
    logic [smx_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [smx_pkg::SUM_W:0]        rem_reg,  rem_next;
    logic [smx_pkg::QUOT_W-1:0]     quot_reg, quot_next;
    logic [smx_pkg::SUM_W:0]        trial;
    logic                           fits;

    always_comb
    begin
        trial     = {rem_reg[smx_pkg::SUM_W-1:0], 1'b0};
        fits      = (trial >= {1'b0, divisor});
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (go)
        begin
            run_next  = 1'b1;
            step_next = smx_pkg::STEP_W'(smx_pkg::DIV_STEPS);
            rem_next  = smx_pkg::DIV_REM_INIT;
            quot_next = '0;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? (trial - {1'b0, divisor}) : trial;
            quot_next = {quot_reg[smx_pkg::QUOT_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == smx_pkg::STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- sv/fixed_point_softmax_pow2.sv -----
// Power-of-two softmax over a vector of signed q17.14 scores.
//
// Input channel: a beat is taken at a rising edge where start is high and busy is
// low. The beat carries one score and in_last, which closes the vector. While a
// vector is being collected busy stays low, so one beat per cycle is accepted.
// Scores beyond MAX_LEN are dropped and flag overflow on every result of that vector.
//
// Output channel: after the closing beat busy rises and the block runs a sum pass over
// the score memory, a serial divide of 17 steps and an emit pass. Results leave in arrival
// order, one per cycle, each shown for exactly one cycle with strobe high; the receiver
// cannot stall and must take every beat.
// Busy falls in the cycle after the last result. The processing time is set by the score
// memory's single read port, walked once per pass, and the bit-serial divider.
//
// Reset clears the control state, the running maximum, the sum and the overflow flag;
// the score memory is not cleared, since only entries written for the current vector
// are read back.
`include "fixed_point_softmax_pow2_defines.svh"

module fixed_point_softmax_pow2 (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  smx_pkg::smx_item_t    item,
    output logic                  strobe,
    output smx_pkg::smx_result_t  result
);

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_SUM,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                                 state_reg,   state_next;
    logic                                   busy_reg,    busy_next;
    logic [smx_pkg::CNT_W-1:0]              count_reg,   count_next;
    logic signed [smx_pkg::SCORE_W-1:0]     max_reg,     max_next;
    logic [smx_pkg::SUM_W-1:0]              sum_reg,     sum_next;
    logic                                   dropped_reg, dropped_next;
    logic [smx_pkg::CNT_W-1:0]              iss_reg,     iss_next;
    logic                                   s1_vld_reg,  s1_vld_next;
    logic                                   s1_last_reg, s1_last_next;
    logic                                   s2_vld_reg,  s2_vld_next;
    logic                                   s2_last_reg, s2_last_next;
    logic [smx_pkg::DIFF_W-1:0]             diff_reg,    diff_next;
    logic                                   div_go_reg,  div_go_next;
    logic                                   strobe_reg,  strobe_next;
    smx_pkg::smx_result_t                   result_reg,  result_next;

    // Score memory: one write port for collection, one registered read port for the passes.
    logic signed [smx_pkg::SCORE_W-1:0]     score_mem [smx_pkg::MAX_LEN];
    logic signed [smx_pkg::SCORE_W-1:0]     rd_data_reg;
    logic                                   wr_en;
    logic                                   rd_en;
    logic [smx_pkg::ADDR_W-1:0]             rd_addr;

    logic                                   accept;
    logic                                   has_room;
    logic                                   pipe_empty;
    logic                                   in_window;
    logic [smx_pkg::SPAN_W-1:0]             span;
    logic [smx_pkg::ARG_W-1:0]              exp_arg;
    logic [smx_pkg::ARG_W-1:0]              sh_arg;
    logic [smx_pkg::EXP_W-1:0]              exp_val;
    logic [smx_pkg::EXP_W-1:0]              shift;
    logic [smx_pkg::SUM_W-1:0]              power;
    logic [smx_pkg::QUOT_W-1:0]             shifted;
    logic [smx_pkg::PROB_W-1:0]             prob;
    logic                                   div_done;
    logic [smx_pkg::QUOT_W-1:0]             div_quot;

    smx_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go_reg),
        .divisor (sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign accept   = start && !busy_reg;
    assign has_room = (count_reg < smx_pkg::CNT_W'(smx_pkg::MAX_LEN));
    assign wr_en    = accept && has_room;
    assign rd_en    = ((state_reg == ST_SUM) || (state_reg == ST_EMIT)) && (iss_reg != count_reg);
    assign rd_addr  = iss_reg[smx_pkg::ADDR_W-1:0];
    assign pipe_empty = !rd_en && !s1_vld_reg && !s2_vld_reg;

    // A score lies inside the 16.0 window when its distance below the maximum is
    // under 2^18. Inside it, the power term is 2^((8192 + 2^18 - span) >> 14) and
    // the output shift is 1 + ((8191 + span) >> 14).
    always_comb
    begin
        in_window = (diff_reg[smx_pkg::DIFF_W-1:smx_pkg::SPAN_W] == '0);
        span      = diff_reg[smx_pkg::SPAN_W-1:0];
        exp_arg   = smx_pkg::ROUND_UP_SPAN - {1'b0, span};
        sh_arg    = smx_pkg::ROUND_DN + {1'b0, span};
        exp_val   = exp_arg[smx_pkg::ARG_W-1:smx_pkg::FRAC_W];
        shift     = smx_pkg::EXP_W'(1) + sh_arg[smx_pkg::ARG_W-1:smx_pkg::FRAC_W];
        power     = smx_pkg::SUM_W'(1) << exp_val;
        shifted   = div_quot >> shift;
        if (!in_window)
        begin
            prob = '0;
        end
        else if (shifted[smx_pkg::QUOT_W-1:smx_pkg::PROB_W] != '0)
        begin
            prob = smx_pkg::PROB_MAX;
        end
        else
        begin
            prob = shifted[smx_pkg::PROB_W-1:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        busy_next    = busy_reg;
        count_next   = count_reg;
        max_next     = max_reg;
        sum_next     = sum_reg;
        dropped_next = dropped_reg;
        iss_next     = iss_reg;
        s1_vld_next  = rd_en;
        s1_last_next = (iss_reg + 1'b1) == count_reg;
        s2_vld_next  = s1_vld_reg;
        s2_last_next = s1_last_reg;
        diff_next    = {max_reg[smx_pkg::SCORE_W-1], max_reg}
                     - {rd_data_reg[smx_pkg::SCORE_W-1], rd_data_reg};
        div_go_next  = 1'b0;
        strobe_next  = 1'b0;
        result_next  = result_reg;

        if (rd_en)
        begin
            iss_next = iss_reg + 1'b1;
        end

        case (state_reg)
            ST_COLLECT:
            begin
                if (accept)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + 1'b1;
                        if (item.value > max_reg)
                        begin
                            max_next = item.value;
                        end
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (item.in_last)
                    begin
                        state_next = ST_SUM;
                        busy_next  = 1'b1;
                        iss_next   = '0;
                    end
                end
            end
            ST_SUM:
            begin
                if (s2_vld_reg && in_window)
                begin
                    sum_next = sum_reg + power;
                end
                if (pipe_empty)
                begin
                    state_next  = ST_DIV;
                    div_go_next = 1'b1;
                    iss_next    = '0;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (s2_vld_reg)
                begin
                    strobe_next          = 1'b1;
                    result_next.prob     = prob;
                    result_next.out_last = s2_last_reg;
                    result_next.overflow = dropped_reg;
                end
                if (pipe_empty)
                begin
                    state_next   = ST_COLLECT;
                    busy_next    = 1'b0;
                    count_next   = '0;
                    max_next     = smx_pkg::SCORE_MIN;
                    sum_next     = '0;
                    dropped_next = 1'b0;
                    iss_next     = '0;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            max_reg     <= smx_pkg::SCORE_MIN;
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
            iss_reg     <= '0;
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
            div_go_reg  <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            count_reg   <= count_next;
            max_reg     <= max_next;
            sum_reg     <= sum_next;
            dropped_reg <= dropped_next;
            iss_reg     <= iss_next;
            s1_vld_reg  <= s1_vld_next;
            s1_last_reg <= s1_last_next;
            s2_vld_reg  <= s2_vld_next;
            s2_last_reg <= s2_last_next;
            div_go_reg  <= div_go_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        diff_reg   <= diff_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            score_mem[count_reg[smx_pkg::ADDR_W-1:0]] <= item.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= score_mem[rd_addr];
        end
    end

    assign busy   = busy_reg;
    assign strobe = strobe_reg;
    assign result = result_reg;

    `SMX_ASSERT_NOW(a_strobe_only_busy, strobe_reg |-> busy_reg, "result beat outside a vector")
    `SMX_ASSERT_NEXT(a_last_sets_busy, accept && item.in_last, busy_reg, "busy did not rise")
    `SMX_ASSERT_NOW(a_sum_floor, div_go_reg |-> (sum_reg[smx_pkg::SUM_W-1:16] != '0), "sum below 2^16")
    `SMX_ASSERT_NOW(a_count_bound, count_reg <= smx_pkg::CNT_W'(smx_pkg::MAX_LEN), "count overrun")
    `SMX_ASSERT_NOW(a_no_read_collect, (state_reg == ST_COLLECT) |-> !s2_vld_reg, "read in collect")

endmodule

// ----- tb/sv/fixed_point_softmax_pow2_test.sv -----
module fixed_point_softmax_pow2_test;

    // One row of the directed stimulus. When typed is set, the result that this
    // beat's score produces is given by hand in want; otherwise the predictor decides.
    typedef struct packed {
        smx_pkg::smx_item_t   beat;
        logic                 typed;
        smx_pkg::smx_result_t want;
    } directed_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    smx_pkg::smx_item_t   item;
    logic                 strobe;
    smx_pkg::smx_result_t result;

    // Predictor state: the kept scores of the vector being collected, widened so
    // that the base below the maximum never wraps.
    longint               kept_scores [smx_pkg::MAX_LEN];
    logic                 kept_typed  [smx_pkg::MAX_LEN];
    smx_pkg::smx_result_t kept_want   [smx_pkg::MAX_LEN];
    int                   kept_count;
    longint               vector_peak;
    logic                 scores_dropped;

    // Confidences still to come out of the block, oldest first.
    smx_pkg::smx_result_t expected_probs [$];
    directed_row_t        directed_rows [$];
    int                   mismatch_count;
    int                   random_beats;
    int                   vector_count;

    fixed_point_softmax_pow2 dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic clear_vector();
        kept_count     = 0;
        vector_peak    = -(longint'(1) <<< 31);
        scores_dropped = 1'b0;
    endtask

    // Works out the confidences of the closed vector and queues them in order.
    task automatic close_vector();
        longint                     base;
        longint                     d;
        longint                     t;
        logic [smx_pkg::SUM_W-1:0]  pow_sum;
        longint unsigned            quot;
        longint unsigned            p;
        int                         e;
        int                         sh;
        smx_pkg::smx_result_t       r;
        base    = vector_peak - (longint'(16) <<< 14);
        pow_sum = '0;
        for (int i = 0; i < kept_count; i++)
        begin
            d = kept_scores[i] - base;
            if (d > 0)
            begin
                e = int'((longint'(8192) + d) >>> 14);
                if (e > 22)
                    e = 22;
                pow_sum = pow_sum + (smx_pkg::SUM_W'(1) << e);
            end
        end
        quot = (pow_sum != '0) ? ((64'd1 << 32) / 64'(pow_sum)) : 64'd0;
        for (int i = 0; i < kept_count; i++)
        begin
            d = kept_scores[i] - base;
            p = 0;
            if (d > 0)
            begin
                t = longint'(8191) - d + (longint'(16) <<< 14);
                if (t < 0)
                    t = 0;
                sh = 1 + int'(t >>> 14);
                if (sh > 63)
                    sh = 63;
                p = quot >> sh;
                if (p > 64'd32767)
                    p = 64'd32767;
            end
            r.prob     = p[smx_pkg::PROB_W-1:0];
            r.out_last = (i + 1 == kept_count);
            r.overflow = scores_dropped;
            expected_probs.push_back(kept_typed[i] ? kept_want[i] : r);
        end
        clear_vector();
    endtask

    // Folds one accepted beat into the predictor.
    task automatic take_score(input smx_pkg::smx_item_t b, input logic typed,
                              input smx_pkg::smx_result_t want);
        longint v;
        v = longint'(b.value);
        if (kept_count < smx_pkg::MAX_LEN)
        begin
            kept_scores[kept_count] = v;
            kept_typed[kept_count]  = typed;
            kept_want[kept_count]   = want;
            kept_count++;
            if (v > vector_peak)
                vector_peak = v;
        end
        else
        begin
            scores_dropped = 1'b1;
        end
        if (b.in_last)
            close_vector();
    endtask

    // Offers one beat after gap idle cycles and returns at the edge that takes it.
    // The caller returns here in the step of that edge, so start is either kept
    // high for a back-to-back beat or lowered here, never both.
    task automatic send_beat(input smx_pkg::smx_item_t b, input int gap, input logic typed,
                             input smx_pkg::smx_result_t want);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= b;
        do
            @(posedge clk);
        while (busy);
        take_score(b, typed, want);
    endtask

    // Holds the sender off until every queued confidence has come out. Start is
    // only lowered when it is still high, so a second drain in the same step
    // leaves it alone.
    task automatic drain_results();
        if (start)
            start <= 1'b0;
        while (expected_probs.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [smx_pkg::SCORE_W-1:0] value, input logic last,
                           input logic typed, input int prob, input logic olast,
                           input logic ovf);
        directed_row_t row;
        row.beat.value    = value;
        row.beat.in_last  = last;
        row.typed         = typed;
        row.want.prob     = smx_pkg::PROB_W'(prob);
        row.want.out_last = olast;
        row.want.overflow = ovf;
        directed_rows.push_back(row);
    endtask

    // Result checker. The block cannot be held off, so every strobe is a beat
    // that must match the oldest expectation.
    always @(posedge clk)
    begin
        smx_pkg::smx_result_t want;
        if (rst_n && strobe)
        begin
            if (expected_probs.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result prob=%0d last=%0b ovf=%0b",
                                        result.prob, result.out_last, result.overflow));
            end
            else
            begin
                want = expected_probs.pop_front();
                if (result.prob !== want.prob)
                    flag_mismatch($sformatf("prob %0d, wanted %0d", result.prob, want.prob));
                if (result.out_last !== want.out_last)
                    flag_mismatch($sformatf("out_last %0b, wanted %0b",
                                            result.out_last, want.out_last));
                if (result.overflow !== want.overflow)
                    flag_mismatch($sformatf("overflow %0b, wanted %0b",
                                            result.overflow, want.overflow));
            end
        end
    end

    // Stimulus: a directed table first, then random vectors of mostly short length.
    initial
    begin
        smx_pkg::smx_item_t     b;
        smx_pkg::smx_result_t   none;
        logic [31:0]            center;
        logic [31:0]            raw;
        int                     len;
        int                     pick;
        int                     style;
        logic                   burst;
        mismatch_count = 0;
        random_beats   = 0;
        vector_count   = 0;
        none           = '0;
        clear_vector();
        rst_n <= 1'b0;
        start <= 1'b0;
        item  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone score always holds the whole mass: 2^15 saturates to full scale.
        add_row(32'h7fff_ffff, 1'b1, 1'b1, 32767, 1'b1, 1'b0);
        add_row(32'h8000_0000, 1'b1, 1'b1, 32767, 1'b1, 1'b0);
        // The top score against the bottom one: the bottom is far below the base.
        add_row(32'h7fff_ffff, 1'b0, 1'b1, 32767, 1'b0, 1'b0);
        add_row(32'h8000_0000, 1'b1, 1'b1, 0, 1'b1, 1'b0);
        // Two equal scores split the mass in halves.
        add_row(-(3 << 14), 1'b0, 1'b1, 16384, 1'b0, 1'b0);
        add_row(-(3 << 14), 1'b1, 1'b1, 16384, 1'b1, 1'b0);
        // Seventeen equal scores: the last, which closes the vector, is dropped, so
        // out_last moves to the sixteenth and every result flags overflow.
        for (int i = 0; i < smx_pkg::MAX_LEN - 1; i++)
            add_row(32'd0, 1'b0, 1'b1, 2048, 1'b0, 1'b1);
        add_row(32'd0, 1'b0, 1'b1, 2048, 1'b1, 1'b1);
        add_row(32'd0, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        // Scores sitting exactly on the base and one step above it.
        add_row(32'(16 << 14), 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(32'd0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(32'd1, 1'b1, 1'b0, 0, 1'b0, 1'b0);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, $urandom_range(0, 10),
                      directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        while (random_beats < 120)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                len = $urandom_range(1, 4);
            else if (pick < 18)
                len = $urandom_range(5, smx_pkg::MAX_LEN);
            else
                len = $urandom_range(smx_pkg::MAX_LEN + 1, smx_pkg::MAX_LEN + 4);
            // Most vectors cluster within 20.0 below a center, around the 16.0 window, so
            // the sum and shifts vary, some at the extremes; the rest are raw 32-bit noise.
            style = $urandom_range(0, 3);
            if (style == 3)
                center = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8005_0000;
            else
                center = $urandom;
            burst = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < len; k++)
            begin
                if (style == 0)
                    raw = $urandom;
                else
                    raw = center - 32'($urandom_range(0, 20 << 14));
                b.value   = raw;
                b.in_last = (k == len - 1);
                send_beat(b, burst ? 0 : $urandom_range(0, 10), 1'b0, none);
                random_beats++;
            end
            vector_count++;
            if (vector_count % 6 == 0)
                drain_results();
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("fixed_point_softmax_pow2: match");
        else
            $display("fixed_point_softmax_pow2: mismatch");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("fixed_point_softmax_pow2: mismatch");
        $finish;
    end

endmodule
